// File: design/tcl_pkg.sv
// shared types and constants for the trilinear colour lut core
// no dependencies; every other design file refers to this package by scoped names
package tcl_pkg;

    localparam int MAX_GRID   = 33;
    localparam int DEPTH      = MAX_GRID * MAX_GRID * MAX_GRID;
    localparam int AW         = $clog2(DEPTH);
    localparam int GRID_W     = $clog2(MAX_GRID + 1);
    localparam int CELL_W     = $clog2(MAX_GRID - 1);
    localparam int NSQ_W      = $clog2(MAX_GRID * MAX_GRID + 1);
    localparam int FRAC_BITS  = 12;
    localparam int FRAC_W     = FRAC_BITS + 1;
    localparam int ONE_Q12    = 1 << FRAC_BITS;
    localparam int WRG_W      = 2 * FRAC_BITS + 1;
    localparam int W_W        = 3 * FRAC_BITS + 1;
    localparam int ACC_W      = 54;
    localparam int RND_SHIFT  = 3 * FRAC_BITS;
    localparam int Q_W        = ACC_W - RND_SHIFT;
    localparam int CORNERS    = 8;
    localparam int COPIES     = CORNERS / 2;
    localparam int STAGES     = 7;
    localparam int PXW        = 16;

    // transaction kind
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_LOAD   = 1'b1
    } t_op;

    // one rgb triple, red in the low bits as stored in the table
    typedef struct packed {
        logic signed [PXW-1:0] blue;
        logic signed [PXW-1:0] green;
        logic signed [PXW-1:0] red;
    } t_rgb;

    // per-stage advance enables passed from the pipeline control
    typedef struct packed {
        logic [STAGES-1:0] en;
    } t_pipe_ctl;

endpackage

// File: design/tcl_ifs.sv
// valid/ready channel interfaces for pixel input and pixel output
// depends on tcl_pkg for the pixel width
interface tcl_in_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic [15:0]                    entry_index;
    logic signed [tcl_pkg::PXW-1:0] red;
    logic signed [tcl_pkg::PXW-1:0] green;
    logic signed [tcl_pkg::PXW-1:0] blue;

    modport source (output valid, op, entry_index, red, green, blue, input ready);
    modport sink   (input valid, op, entry_index, red, green, blue, output ready);
endinterface

interface tcl_out_if;
    logic                           valid;
    logic                           ready;
    logic signed [tcl_pkg::PXW-1:0] out_red;
    logic signed [tcl_pkg::PXW-1:0] out_green;
    logic signed [tcl_pkg::PXW-1:0] out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

// File: design/tcl_coord.sv
// clamp, scale and split of each colour channel into lattice cell and fraction
// depends on tcl_pkg
module tcl_coord (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_chk_vld,
    input  tcl_pkg::t_rgb                         i_px,
    input  logic [tcl_pkg::GRID_W-1:0]            i_n,
    output logic [2:0][tcl_pkg::CELL_W-1:0]       o_cell,
    output logic [2:0][tcl_pkg::FRAC_W-1:0]       o_frac,
    output logic                                  o_pass
);

    logic [2:0][tcl_pkg::PXW-1:0]    n_chan;
    logic [2:0][tcl_pkg::CELL_W-1:0] n_cell;
    logic [2:0][tcl_pkg::FRAC_W-1:0] n_frac;
    logic [2:0][tcl_pkg::CELL_W-1:0] r_cell;
    logic [2:0][tcl_pkg::FRAC_W-1:0] r_frac;
    logic                            r_pass;
    logic [tcl_pkg::GRID_W-1:0]      d;
    logic [tcl_pkg::GRID_W-1:0]      dm1;

    assign n_chan = {i_px.blue, i_px.green, i_px.red};
    assign d      = i_n - tcl_pkg::GRID_W'(1);
    assign dm1    = d - tcl_pkg::GRID_W'(1);

    // per channel: clamp to 0..1.0, scale by n-1, cap the cell
    always_comb begin
        logic [tcl_pkg::FRAC_W-1:0]           v;
        logic [tcl_pkg::FRAC_W+tcl_pkg::GRID_W-1:0] p;
        logic [tcl_pkg::GRID_W:0]             c;
        logic [tcl_pkg::GRID_W-1:0]           cc;
        logic [tcl_pkg::FRAC_W+tcl_pkg::GRID_W-1:0] diff;
        for (int k = 0; k < 3; k++) begin
            if (n_chan[k][tcl_pkg::PXW-1]) begin
                v = '0;
            end else if (n_chan[k] > tcl_pkg::PXW'(tcl_pkg::ONE_Q12)) begin
                v = tcl_pkg::FRAC_W'(tcl_pkg::ONE_Q12);
            end else begin
                v = n_chan[k][tcl_pkg::FRAC_W-1:0];
            end
            p = {{tcl_pkg::GRID_W{1'b0}}, v} * {{tcl_pkg::FRAC_W{1'b0}}, d};
            c = p[tcl_pkg::FRAC_W+tcl_pkg::GRID_W-1:tcl_pkg::FRAC_BITS];
            if (c > {1'b0, dm1}) begin
                cc = dm1;
            end else begin
                cc = c[tcl_pkg::GRID_W-1:0];
            end
            diff      = p - {1'b0, cc, {tcl_pkg::FRAC_BITS{1'b0}}};
            n_cell[k] = cc[tcl_pkg::CELL_W-1:0];
            n_frac[k] = diff[tcl_pkg::FRAC_W-1:0];
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
            r_frac <= n_frac;
            r_pass <= (i_n < tcl_pkg::GRID_W'(2));
        end
    end

    assign o_cell = r_cell;
    assign o_frac = r_frac;
    assign o_pass = r_pass;

    // cell never reaches the last lattice point
    a_cell_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_chk_vld && !r_pass) |->
        ({1'b0, r_cell[0]} <= i_n - tcl_pkg::GRID_W'(2)) &&
        ({1'b0, r_cell[1]} <= i_n - tcl_pkg::GRID_W'(2)) &&
        ({1'b0, r_cell[2]} <= i_n - tcl_pkg::GRID_W'(2)))
        else $error("lattice cell beyond grid");

    // fraction stays within one cell
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_chk_vld && !r_pass) |->
        (r_frac[0] <= tcl_pkg::FRAC_W'(tcl_pkg::ONE_Q12)) &&
        (r_frac[1] <= tcl_pkg::FRAC_W'(tcl_pkg::ONE_Q12)) &&
        (r_frac[2] <= tcl_pkg::FRAC_W'(tcl_pkg::ONE_Q12)))
        else $error("fraction above one");

endmodule

// File: design/tcl_lut_mem.sv
// table storage: four identical copies with two read ports each, one per corner
// depends on tcl_pkg
module tcl_lut_mem (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic                                 i_wr,
    input  logic [15:0]                          i_wr_addr,
    input  tcl_pkg::t_rgb                        i_wr_data,
    input  logic [2:0][tcl_pkg::CELL_W-1:0]      i_cell,
    input  logic [tcl_pkg::GRID_W-1:0]           i_n,
    input  logic [tcl_pkg::NSQ_W-1:0]            i_nsq,
    output tcl_pkg::t_rgb                        o_rd [tcl_pkg::CORNERS]
);

    logic [tcl_pkg::AW-1:0] rd_addr [tcl_pkg::CORNERS];
    logic [tcl_pkg::AW:0]   base;
    logic                   wr_ok;

    // flat index of the cell origin, two independent products
    assign base = (tcl_pkg::AW+1)'({{tcl_pkg::NSQ_W{1'b0}}, i_cell[2]} *
                                   {{tcl_pkg::CELL_W{1'b0}}, i_nsq})
                + (tcl_pkg::AW+1)'({{tcl_pkg::GRID_W{1'b0}}, i_cell[1]} *
                                   {{tcl_pkg::CELL_W{1'b0}}, i_n})
                + (tcl_pkg::AW+1)'(i_cell[0]);

    // corner offsets: red +1, green +n, blue +n*n
    always_comb begin
        logic [tcl_pkg::AW:0] off;
        for (int k = 0; k < tcl_pkg::CORNERS; k++) begin
            off = (tcl_pkg::AW+1)'(k % 2);
            if (((k / 2) % 2) == 1) begin
                off = off + (tcl_pkg::AW+1)'(i_n);
            end
            if (k / 4 == 1) begin
                off = off + (tcl_pkg::AW+1)'(i_nsq);
            end
            rd_addr[k] = tcl_pkg::AW'(base + off);
        end
    end

    assign wr_ok = i_wr && ({1'b0, i_wr_addr} < 17'(tcl_pkg::DEPTH));

    // each copy written alike, read at two corners
    for (genvar j = 0; j < tcl_pkg::COPIES; j++) begin : g_copy
        tcl_pkg::t_rgb r_mem [tcl_pkg::DEPTH];

        always_ff @(posedge i_clk) begin
            if (i_en && wr_ok) begin
                r_mem[i_wr_addr[tcl_pkg::AW-1:0]] <= i_wr_data;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                o_rd[2*j]   <= r_mem[rd_addr[2*j]];
                o_rd[2*j+1] <= r_mem[rd_addr[2*j+1]];
            end
        end
    end

endmodule

// File: design/tcl_blend.sv
// corner weights, weighted products, summation, rounding and saturation, or pixel pass-through
// depends on tcl_pkg; fed by tcl_coord and tcl_lut_mem
module tcl_blend (
    input  logic                                 i_clk,
    input  tcl_pkg::t_pipe_ctl                   i_ctl,
    input  logic [2:0][tcl_pkg::FRAC_W-1:0]      i_frac,
    input  logic                                 i_pass,
    input  tcl_pkg::t_rgb                        i_px,
    input  tcl_pkg::t_rgb                        i_rd [tcl_pkg::CORNERS],
    output tcl_pkg::t_rgb                        o_rgb
);

    localparam logic signed [tcl_pkg::ACC_W-1:0] RND =
        tcl_pkg::ACC_W'(1) << (tcl_pkg::RND_SHIFT - 1);

    logic [tcl_pkg::WRG_W-1:0]          r_wrg [4];
    logic [tcl_pkg::FRAC_W-1:0]         r_wb [2];
    logic [tcl_pkg::W_W-1:0]            r_w [tcl_pkg::CORNERS];
    tcl_pkg::t_rgb                      r_ent [tcl_pkg::CORNERS];
    logic signed [tcl_pkg::ACC_W-1:0]   r_prod [tcl_pkg::CORNERS][3];
    logic signed [tcl_pkg::ACC_W-1:0]   r_pair [4][3];
    tcl_pkg::t_rgb                      r_px [2:5];
    logic                               r_pass [2:5];
    tcl_pkg::t_rgb                      r_out;
    tcl_pkg::t_rgb                      n_out;
    logic [tcl_pkg::FRAC_W-1:0]         lo [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lo[k] = tcl_pkg::FRAC_W'(tcl_pkg::ONE_Q12) - i_frac[k];
        end
    end

    // red and green weight products, blue weights kept for the next stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            for (int i = 0; i < 4; i++) begin
                r_wrg[i] <= {{(tcl_pkg::WRG_W-tcl_pkg::FRAC_W){1'b0}},
                             ((i / 2) == 1) ? i_frac[1] : lo[1]}
                          * {{(tcl_pkg::WRG_W-tcl_pkg::FRAC_W){1'b0}},
                             ((i % 2) == 1) ? i_frac[0] : lo[0]};
            end
            r_wb[0]   <= lo[2];
            r_wb[1]   <= i_frac[2];
            r_px[2]   <= i_px;
            r_pass[2] <= i_pass;
        end
    end

    // full corner weights
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            for (int k = 0; k < tcl_pkg::CORNERS; k++) begin
                r_w[k]   <= {{(tcl_pkg::W_W-tcl_pkg::WRG_W){1'b0}}, r_wrg[k % 4]}
                          * {{(tcl_pkg::W_W-tcl_pkg::FRAC_W){1'b0}}, r_wb[k / 4]};
                r_ent[k] <= i_rd[k];
            end
            r_px[3]   <= r_px[2];
            r_pass[3] <= r_pass[2];
        end
    end

    // weight times entry, per corner and channel
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            for (int k = 0; k < tcl_pkg::CORNERS; k++) begin
                r_prod[k][0] <= $signed({1'b0, r_w[k]}) * r_ent[k].red;
                r_prod[k][1] <= $signed({1'b0, r_w[k]}) * r_ent[k].green;
                r_prod[k][2] <= $signed({1'b0, r_w[k]}) * r_ent[k].blue;
            end
            r_px[4]   <= r_px[3];
            r_pass[4] <= r_pass[3];
        end
    end

    // pair sums
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[5]) begin
            for (int i = 0; i < 4; i++) begin
                for (int c = 0; c < 3; c++) begin
                    r_pair[i][c] <= r_prod[2*i][c] + r_prod[2*i+1][c];
                end
            end
            r_px[5]   <= r_px[4];
            r_pass[5] <= r_pass[4];
        end
    end

    // final sum, round half up, saturate, or pass the pixel through
    always_comb begin
        logic signed [tcl_pkg::ACC_W-1:0] acc;
        logic signed [tcl_pkg::Q_W-1:0]   q;
        logic signed [tcl_pkg::PXW-1:0]   s [3];
        for (int c = 0; c < 3; c++) begin
            acc = r_pair[0][c] + r_pair[1][c] + r_pair[2][c] + r_pair[3][c] + RND;
            q   = acc[tcl_pkg::ACC_W-1:tcl_pkg::RND_SHIFT];
            if (q > tcl_pkg::Q_W'(32767)) begin
                s[c] = 16'sh7fff;
            end else if (q < -tcl_pkg::Q_W'(32768)) begin
                s[c] = 16'sh8000;
            end else begin
                s[c] = q[tcl_pkg::PXW-1:0];
            end
        end
        if (r_pass[5]) begin
            n_out = r_px[5];
        end else begin
            n_out = {s[2], s[1], s[0]};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[6]) begin
            r_out <= n_out;
        end
    end

    assign o_rgb = r_out;

endmodule

// File: design/trilinear_color_lut_core.sv
// trilinear 3d colour lut: seven-stage pipeline, one transaction per cycle sustained while
// the output accepts results; the rate is set by the four two-port table copies that
// serve all eight corners together.
// loads retire at the table read stage and give no result.
// synchronous active-low reset clears stage valids and grid_size; table contents are
// undefined until loaded, no clearing pass. uses tcl_pkg, tcl_ifs and the tcl_* blocks
module trilinear_color_lut_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tcl_in_if.sink       i_in_ch,
    tcl_out_if.source    o_out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [tcl_pkg::STAGES-1:0]        r_v;
    logic [tcl_pkg::STAGES-1:0]        en;
    tcl_pkg::t_pipe_ctl                ctl;
    tcl_pkg::t_op                      r_op0;
    tcl_pkg::t_op                      r_op1;
    logic [15:0]                       r_idx0;
    logic [15:0]                       r_idx1;
    tcl_pkg::t_rgb                     r_px0;
    tcl_pkg::t_rgb                     r_px1;
    logic [tcl_pkg::GRID_W-1:0]        r_grid;
    logic [tcl_pkg::GRID_W-1:0]        r_n;
    logic [tcl_pkg::NSQ_W-1:0]         r_nsq;
    logic [tcl_pkg::GRID_W-1:0]        n_n;
    logic                              cfg_wr;
    logic [2:0][tcl_pkg::CELL_W-1:0]   lat_cell;
    logic [2:0][tcl_pkg::FRAC_W-1:0]   frac;
    logic                              pass;
    tcl_pkg::t_rgb                     rd [tcl_pkg::CORNERS];
    tcl_pkg::t_rgb                     out_rgb;
    logic                              smp1;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign n_n    = (pwdata[tcl_pkg::GRID_W-1:0] > tcl_pkg::GRID_W'(tcl_pkg::MAX_GRID))
                  ? tcl_pkg::GRID_W'(tcl_pkg::MAX_GRID) : pwdata[tcl_pkg::GRID_W-1:0];
    assign prdata = (paddr[2] == 1'b0) ? {{(32-tcl_pkg::GRID_W){1'b0}}, r_grid} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= '0;
            r_n    <= '0;
            r_nsq  <= '0;
        end else if (cfg_wr) begin
            r_grid <= pwdata[tcl_pkg::GRID_W-1:0];
            r_n    <= n_n;
            r_nsq  <= tcl_pkg::NSQ_W'({{tcl_pkg::GRID_W{1'b0}}, n_n} *
                                      {{tcl_pkg::GRID_W{1'b0}}, n_n});
        end
    end

    // per-stage advance: a stage moves when empty or when the next one moves
    always_comb begin
        en[tcl_pkg::STAGES-1] = !r_v[tcl_pkg::STAGES-1] || o_out_ch.ready;
        for (int s = tcl_pkg::STAGES - 2; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign ctl.en         = en;
    assign i_in_ch.ready  = en[0];
    assign smp1           = r_v[1] && (r_op1 == tcl_pkg::OP_SAMPLE);

    // valid bits, loads leave after the table stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_in_ch.valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= smp1;
            for (int s = 3; s < tcl_pkg::STAGES; s++) begin
                if (en[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    // input and first stage payload
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_op0  <= tcl_pkg::t_op'(i_in_ch.op);
            r_idx0 <= i_in_ch.entry_index;
            r_px0  <= {i_in_ch.blue, i_in_ch.green, i_in_ch.red};
        end
        if (en[1]) begin
            r_op1  <= r_op0;
            r_idx1 <= r_idx0;
            r_px1  <= r_px0;
        end
    end

    tcl_coord u_coord (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en[1]),
        .i_chk_vld (smp1),
        .i_px      (r_px0),
        .i_n       (r_n),
        .o_cell    (lat_cell),
        .o_frac    (frac),
        .o_pass    (pass)
    );

    tcl_lut_mem u_mem (
        .i_clk     (i_clk),
        .i_en      (en[2]),
        .i_wr      (r_v[1] && (r_op1 == tcl_pkg::OP_LOAD)),
        .i_wr_addr (r_idx1),
        .i_wr_data (r_px1),
        .i_cell    (lat_cell),
        .i_n       (r_n),
        .i_nsq     (r_nsq),
        .o_rd      (rd)
    );

    tcl_blend u_blend (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_frac (frac),
        .i_pass (pass),
        .i_px   (r_px1),
        .i_rd   (rd),
        .o_rgb  (out_rgb)
    );

    assign o_out_ch.valid     = r_v[tcl_pkg::STAGES-1];
    assign o_out_ch.out_red   = out_rgb.red;
    assign o_out_ch.out_green = out_rgb.green;
    assign o_out_ch.out_blue  = out_rgb.blue;

    // input back-pressure only when every stage holds a transaction
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en[0] |-> (&r_v))
        else $error("input stalled with a bubble in the pipeline");

    // an accepted transaction occupies the first stage
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_ch.valid && i_in_ch.ready) |=> r_v[0])
        else $error("accepted transaction lost at entry");

endmodule
